FILE: hw/rtl/abpg_pkg.sv
// ============================================================================
// Alarm blink pattern generator package
// Shared level codes, timing constants, controller states and the command
// and status bundles that pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package abpg_pkg;

    // Field and register widths.
    localparam int LEVEL_W   = 3;
    localparam int MILLIS_W  = 32;
    localparam int ELAPSED_W = 12;
    localparam int REM_W     = 13;   // holds any remainder below the largest divisor
    localparam int FIFTH_W   = 10;   // elapsed / 5 never exceeds 819
    localparam int CNT_W     = $clog2(MILLIS_W);

    // Alert level codes.
    localparam logic [LEVEL_W-1:0] LVL_AWAKE      = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_PRE_DROWSY = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_DROWSY     = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_DISTRACTED = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_MICROSLEEP = 3'd4;

    // Timing constants, in milliseconds.
    localparam int TICK_MS          = 10;
    localparam int ELAPSED_CAP      = 4000;
    localparam int SEC_MS           = 1000;
    localparam int HALF_SEC_MS      = 500;
    localparam int QUARTER_MS       = 250;
    localparam int BUZZ_MS          = 150;
    localparam int DISTRACT_BUZZ_MS = 2500;
    localparam int DISTRACT_FRAME   = 5000;  // common multiple of 1000 and 2500
    localparam int RAMP_ON_MS       = 140;

    // The ramp takes elapsed * 800 / 4000, which is elapsed / 5. Multiplying
    // by 3277 and dropping 14 bits gives the exact floor for 12-bit values.
    localparam int FIFTH_MUL   = 3277;
    localparam int FIFTH_SHIFT = 14;
    localparam int PROD_W      = ELAPSED_W + 12;

    // Configuration register indexes, taken from paddr bit 2.
    localparam logic REG_OVR_ENABLE = 1'b0;
    localparam logic REG_OVR_LEVEL  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIFTH,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic event_load;
        logic tick_load;
        logic calc_fifth;
        logic div_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: hw/rtl/abpg_remdiv.sv
// ============================================================================
// Iterative remainder unit
// Restoring radix-2 division of the millisecond count by a small divisor,
// one dividend bit per cycle; only the remainder is kept.
// ============================================================================
`default_nettype none

module abpg_remdiv
    import abpg_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [MILLIS_W-1:0] i_dividend,
    input  wire logic [REM_W-1:0]    i_divisor,
    output logic                     o_done,
    output logic [REM_W-1:0]         o_rem
);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [MILLIS_W-1:0] r_dvd;
    logic [REM_W-1:0]    r_dvs;
    logic [REM_W-1:0]    r_rem;

    logic [REM_W:0]      w_trial;
    logic [REM_W-1:0]    n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[MILLIS_W-1]};
        if (w_trial >= {1'b0, r_dvs}) begin
            n_rem = REM_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(MILLIS_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[MILLIS_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    // A finished remainder is always below its divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/abpg_datapath.sv
// ============================================================================
// Alarm blink pattern datapath
// Level, millisecond and elapsed-time state, the ramp period, the remainder
// unit, pattern decoding and the result register.
// ============================================================================
`default_nettype none

module abpg_datapath
    import abpg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic [LEVEL_W-1:0] i_new_level,
    input  wire logic               i_ovr_enable,
    input  wire logic [LEVEL_W-1:0] i_ovr_level,
    input  wire logic               i_out_ready,
    output t_status                 o_status,
    output logic                    o_out_valid,
    output logic                    o_led_on,
    output logic                    o_buzzer_on,
    output logic [LEVEL_W-1:0]      o_active_level
);

    logic [LEVEL_W-1:0]   r_level;
    logic [MILLIS_W-1:0]  r_millis;
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [FIFTH_W-1:0]   r_fifth;
    logic                 r_out_valid;
    logic                 r_led;
    logic                 r_buz;
    logic [LEVEL_W-1:0]   r_out_level;

    logic [PROD_W-1:0]    w_prod;
    logic [FIFTH_W-1:0]   w_period;
    logic [FIFTH_W-1:0]   w_ontime;
    logic [REM_W-1:0]     w_divisor;
    logic [REM_W-1:0]     w_rem;
    logic [REM_W-1:0]     w_rem_sec;
    logic [REM_W-1:0]     w_rem_half;
    logic [REM_W-1:0]     w_rem_buzz;
    logic                 w_div_done;
    logic                 n_led;
    logic                 n_buz;
    logic [ELAPSED_W:0]   w_el_sum;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic                 w_take_event;
    logic                 w_take_ovr;

    assign w_prod   = PROD_W'(r_elapsed) * PROD_W'(FIFTH_MUL);
    assign w_period = FIFTH_W'(SEC_MS) - r_fifth;
    assign w_ontime = (w_period > FIFTH_W'(RAMP_ON_MS)) ? FIFTH_W'(RAMP_ON_MS)
                                                         : (w_period >> 1);

    // The distracted level divides by a 5000 ms frame, so that both of its
    // windows come out of a single remainder.
    always_comb begin
        unique case (r_level)
            LVL_DISTRACTED: w_divisor = REM_W'(DISTRACT_FRAME);
            LVL_MICROSLEEP: w_divisor = REM_W'(w_period);
            default:        w_divisor = REM_W'(SEC_MS);
        endcase
    end

    abpg_remdiv u_remdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_millis),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // Fold the remainder down to the shorter windows.
    always_comb begin
        if (w_rem >= REM_W'(HALF_SEC_MS)) begin
            w_rem_half = w_rem - REM_W'(HALF_SEC_MS);
        end else begin
            w_rem_half = w_rem;
        end
        priority if (w_rem >= REM_W'(4 * SEC_MS)) begin
            w_rem_sec = w_rem - REM_W'(4 * SEC_MS);
        end else if (w_rem >= REM_W'(3 * SEC_MS)) begin
            w_rem_sec = w_rem - REM_W'(3 * SEC_MS);
        end else if (w_rem >= REM_W'(2 * SEC_MS)) begin
            w_rem_sec = w_rem - REM_W'(2 * SEC_MS);
        end else if (w_rem >= REM_W'(SEC_MS)) begin
            w_rem_sec = w_rem - REM_W'(SEC_MS);
        end else begin
            w_rem_sec = w_rem;
        end
        if (w_rem >= REM_W'(DISTRACT_BUZZ_MS)) begin
            w_rem_buzz = w_rem - REM_W'(DISTRACT_BUZZ_MS);
        end else begin
            w_rem_buzz = w_rem;
        end
    end

    always_comb begin
        n_led = 1'b0;
        n_buz = 1'b0;
        unique case (r_level)
            LVL_PRE_DROWSY: begin
                n_led = (w_rem < REM_W'(HALF_SEC_MS));
            end
            LVL_DROWSY: begin
                n_led = (w_rem_half < REM_W'(QUARTER_MS));
                n_buz = (w_rem < REM_W'(BUZZ_MS));
            end
            LVL_DISTRACTED: begin
                n_led = (w_rem_sec < REM_W'(QUARTER_MS));
                n_buz = (w_rem_buzz < REM_W'(BUZZ_MS));
            end
            LVL_MICROSLEEP: begin
                if (r_elapsed >= ELAPSED_W'(ELAPSED_CAP)) begin
                    n_led = 1'b1;
                    n_buz = 1'b1;
                end else begin
                    n_led = (w_rem < REM_W'(w_ontime));
                    n_buz = n_led;
                end
            end
            default: begin
                n_led = 1'b0;
                n_buz = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_el_sum = {1'b0, r_elapsed} + (ELAPSED_W + 1)'(TICK_MS);
        if (w_el_sum > (ELAPSED_W + 1)'(ELAPSED_CAP)) begin
            n_elapsed = ELAPSED_W'(ELAPSED_CAP);
        end else begin
            n_elapsed = w_el_sum[ELAPSED_W-1:0];
        end
    end

    assign w_take_event = i_cmd.event_load && !i_ovr_enable && (i_new_level != r_level);
    assign w_take_ovr   = i_cmd.tick_load && i_ovr_enable && (i_ovr_level != r_level);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LVL_AWAKE;
            r_millis  <= '0;
            r_elapsed <= '0;
        end else begin
            priority if (w_take_event) begin
                r_level   <= i_new_level;
                r_elapsed <= '0;
            end else if (w_take_ovr) begin
                r_level   <= i_ovr_level;
                r_elapsed <= '0;
            end else if (i_cmd.finish) begin
                r_millis  <= r_millis + MILLIS_W'(TICK_MS);
                r_elapsed <= n_elapsed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_fifth) begin
            r_fifth <= w_prod[FIFTH_SHIFT +: FIFTH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_led       <= n_led;
            r_buz       <= n_buz;
            r_out_level <= r_level;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_led_on          = r_led;
    assign o_buzzer_on       = r_buz;
    assign o_active_level    = r_out_level;

`ifndef SYNTHESIS
    // The elapsed time saturates and never passes its cap.
    a_elapsed_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_elapsed <= ELAPSED_W'(ELAPSED_CAP))
        else $error("elapsed time beyond cap");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/abpg_ctrl.sv
// ============================================================================
// Alarm blink pattern controller
// Sequences a tick through ramp scaling, the remainder unit and the result
// register; level events complete in the cycle they are taken.
// ============================================================================
`default_nettype none

module abpg_ctrl
    import abpg_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_command,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_command) begin
                    n_state = S_FIFTH;
                end
            end
            S_FIFTH: n_state = S_START;
            S_START: n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_cmd.event_load = (r_state == S_IDLE) && i_in_valid && !i_command;
        o_cmd.tick_load  = (r_state == S_IDLE) && i_in_valid && i_command;
        o_cmd.calc_fifth = (r_state == S_FIFTH);
        o_cmd.div_start  = (r_state == S_START);
        o_cmd.finish     = (r_state == S_DONE) && i_status.out_free;
    end

`ifndef SYNTHESIS
    // The remainder unit only reports completion while a tick waits on it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DIV))
        else $error("divider done outside division state");

    // A taken tick always moves on to ramp scaling.
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_command) |=> (r_state == S_FIFTH))
        else $error("tick not sequenced");

    // A result is only loaded when the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_status.out_free) |=> (r_state == S_DONE))
        else $error("result dropped while output stalled");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/alarm_blink_pattern_generator_top.sv
// ============================================================================
// Alarm blink pattern generator
// Drives a warning LED and buzzer from an alert level, one result per tick.
// ============================================================================
//
//   Channel   Signals          Contents (lowest bit first)
//   -------   --------------   ---------------------------------------------
//   s_axis    tvalid/tready    tdata[2:0] new_level, tuser[0] command
//   m_axis    tvalid/tready    tdata[0] led_on, [1] buzzer_on, [4:2] level
//   apb       psel/penable     0x0 test_override_enable, 0x4 override_level
//
// A level event item is taken without holding the input off and gives no
// result. A tick item holds the input off after its acceptance while the
// controller scales the elapsed time, loads the remainder unit, waits for the
// bit-serial remainder of the 32-bit millisecond count (32 shift steps and
// the done flag) and loads the result; the next item is taken once it is idle
// again. A result waiting in the output register does not block new items;
// only a tick finishing while the previous result is still untaken waits.
// Reset is synchronous, active low, and clears the level, both counters and
// the override registers.
// ============================================================================
`default_nettype none

module alarm_blink_pattern_generator_top
    import abpg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [2:0] new_level
    input  wire logic [0:0]  s_axis_tuser,   // [0] command
    // Result items.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] led_on, [1] buzzer_on, [4:2] active_level
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic               r_ovr_enable;
    logic [LEVEL_W-1:0] r_ovr_level;

    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_led;
    logic               w_buz;
    logic [LEVEL_W-1:0] w_level;
    logic               w_cfg_write;

    // The port never stalls; a write lands on the access cycle.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    // Register index is the word address; the low two bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr_enable <= 1'b0;
            r_ovr_level  <= LVL_AWAKE;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                REG_OVR_ENABLE: r_ovr_enable <= pwdata[0];
                REG_OVR_LEVEL:  r_ovr_level  <= pwdata[LEVEL_W-1:0];
                default:        r_ovr_enable <= r_ovr_enable;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_OVR_ENABLE: prdata = {31'b0, r_ovr_enable};
            REG_OVR_LEVEL:  prdata = {{(32 - LEVEL_W){1'b0}}, r_ovr_level};
            default:        prdata = '0;
        endcase
    end

    // The controller sequences each tick; the datapath holds the level, time and result state.
    abpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_command  (s_axis_tuser[0]),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    abpg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_new_level    (s_axis_tdata[LEVEL_W-1:0]),
        .i_ovr_enable   (r_ovr_enable),
        .i_ovr_level    (r_ovr_level),
        .i_out_ready    (m_axis_tready),
        .o_status       (w_status),
        .o_out_valid    (m_axis_tvalid),
        .o_led_on       (w_led),
        .o_buzzer_on    (w_buz),
        .o_active_level (w_level)
    );

    assign m_axis_tdata = {3'b0, w_level, w_buz, w_led};

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Alarm blink pattern generator testbench
// Streams level events and 10 ms ticks into the block and predicts each tick's
// LED, buzzer and level. It checks every result item in order through four
// phases of source and sink throttling and several override settings.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import abpg_pkg::*;

    // Command codes carried on s_axis_tuser[0].
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // The microsleep period shrinks by this much over the full elapsed range.
    localparam int RAMP_SPAN_MS = 800;

    // A settle wait long enough for a tick to pass through the block.
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic       cmd;
        logic [2:0] lvl;
    } t_alarm_item;

    typedef struct packed {
        logic       led;
        logic       buz;
        logic [2:0] lvl;
    } t_blink;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [2:0] new_level, [7:3] zero
    logic [0:0]  s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] led_on, [1] buzzer_on, [4:2] active_level
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alarm_blink_pattern_generator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Items waiting to be driven and tick results waiting to come out.
    t_alarm_item pending_items[$];
    t_blink      blink_q[$];

    // Predicted state of the block and its override registers.
    logic [2:0]  alert_lvl;
    logic [31:0] ms_count;
    int unsigned lvl_time;
    logic        ovr_en;
    logic [2:0]  ovr_lvl;

    int err_cnt;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    logic item_taken;

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_cnt++;
    endtask

    // Updates the predicted state for one accepted item. A tick also queues
    // the LED and buzzer bits that it must produce.
    task automatic apply_alarm_item(input t_alarm_item it);
        t_blink      r;
        int unsigned m;
        int unsigned period;
        int unsigned on_ms;
        logic        wave;
        if (it.cmd == CMD_EVENT) begin
            // Events are dropped under override, and a repeat of the current
            // level keeps the elapsed time running.
            if (!ovr_en && it.lvl != alert_lvl) begin
                alert_lvl = it.lvl;
                lvl_time  = 0;
            end
        end else begin
            if (ovr_en && ovr_lvl != alert_lvl) begin
                alert_lvl = ovr_lvl;
                lvl_time  = 0;
            end
            m     = ms_count;
            r.led = 1'b0;
            r.buz = 1'b0;
            r.lvl = alert_lvl;
            case (alert_lvl)
                LVL_PRE_DROWSY: begin
                    r.led = (m % SEC_MS) < HALF_SEC_MS;
                end
                LVL_DROWSY: begin
                    r.led = (m % HALF_SEC_MS) < QUARTER_MS;
                    r.buz = (m % SEC_MS) < BUZZ_MS;
                end
                LVL_DISTRACTED: begin
                    r.led = (m % SEC_MS) < QUARTER_MS;
                    r.buz = (m % DISTRACT_BUZZ_MS) < BUZZ_MS;
                end
                LVL_MICROSLEEP: begin
                    // The blink period ramps down with time spent at this
                    // level, and the outputs go steady once it saturates.
                    if (lvl_time >= ELAPSED_CAP) begin
                        r.led = 1'b1;
                        r.buz = 1'b1;
                    end else begin
                        period = SEC_MS - (lvl_time * RAMP_SPAN_MS) / ELAPSED_CAP;
                        on_ms  = (period > RAMP_ON_MS) ? RAMP_ON_MS : period / 2;
                        wave   = (m % period) < on_ms;
                        r.led  = wave;
                        r.buz  = wave;
                    end
                end
                default: begin
                    // Awake and the undefined codes leave both outputs off.
                end
            endcase
            blink_q.push_back(r);
            ms_count = ms_count + TICK_MS;
            lvl_time = (lvl_time + TICK_MS > ELAPSED_CAP) ? ELAPSED_CAP : lvl_time + TICK_MS;
        end
    endtask

    // Input side: a new item is offered at the falling edge once the previous
    // one was taken, unless the source decides to idle for this cycle.
    always @(negedge i_clk) begin : drive_items
        t_alarm_item it;
        if (i_rst_n && (!s_axis_tvalid || item_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'b0, it.lvl};
                s_axis_tuser  <= it.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side backpressure, redrawn every cycle.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: feeds accepted inputs to the predictor and checks each result
    // item against the oldest prediction.
    always @(posedge i_clk) begin : watch_ports
        t_alarm_item it;
        t_blink      want;
        if (i_rst_n) begin
            item_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                it.cmd = s_axis_tuser[0];
                it.lvl = s_axis_tdata[2:0];
                apply_alarm_item(it);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (blink_q.size() == 0) begin
                    flag_error($sformatf("result with nothing expected, tdata=%h",
                                         m_axis_tdata));
                end else begin
                    want = blink_q.pop_front();
                    if (m_axis_tdata[0] !== want.led)
                        flag_error($sformatf("led_on %b, expected %b (level %0d)",
                                             m_axis_tdata[0], want.led, want.lvl));
                    if (m_axis_tdata[1] !== want.buz)
                        flag_error($sformatf("buzzer_on %b, expected %b (level %0d)",
                                             m_axis_tdata[1], want.buz, want.lvl));
                    if (m_axis_tdata[4:2] !== want.lvl)
                        flag_error($sformatf("active_level %0d, expected %0d",
                                             m_axis_tdata[4:2], want.lvl));
                end
            end
        end else begin
            item_taken <= 1'b0;
        end
    end

    // Watchdog: any handshake on any port restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no activity for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Writes one override register, then reads it back.
    task automatic set_reg(input logic idx, input logic [31:0] val);
        logic [31:0] rd;
        logic [31:0] want;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_OVR_ENABLE)
            ovr_en = val[0];
        else
            ovr_lvl = val[2:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = (idx == REG_OVR_ENABLE) ? {31'b0, ovr_en} : {29'b0, ovr_lvl};
        if (rd !== want)
            flag_error($sformatf("register %0d reads %h, expected %h", idx, rd, want));
    endtask

    task automatic queue_item(input logic cmd, input logic [2:0] lvl);
        t_alarm_item it;
        it.cmd = cmd;
        it.lvl = lvl;
        pending_items.push_back(it);
    endtask

    // Waits for every item to go in and every result to come out, then lets
    // the block finish whatever event it may still be digesting.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || blink_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Random runs: a level event followed by a stretch of ticks. Now and then
    // the event is repeated, and stray events break into the stretch.
    task automatic queue_level_runs(input int target);
        int         count;
        int         ticks;
        logic [2:0] lvl;
        count = 0;
        while (count < target) begin
            lvl = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
            queue_item(CMD_EVENT, lvl);
            count++;
            if ($urandom_range(3) == 0) begin
                queue_item(CMD_EVENT, lvl);
                count++;
            end
            ticks = $urandom_range(30, 1);
            repeat (ticks) begin
                if ($urandom_range(11) == 0) begin
                    queue_item(CMD_EVENT, 3'($urandom_range(7)));
                    count++;
                end
                // A tick ignores its level field, so it carries noise there.
                queue_item(CMD_TICK, 3'($urandom_range(7)));
                count++;
            end
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        alert_lvl     = LVL_AWAKE;
        ms_count      = '0;
        lvl_time      = 0;
        ovr_en        = 1'b0;
        ovr_lvl       = '0;
        err_cnt       = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        quiet_cycles  = 0;
        item_taken    = 1'b0;

        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Override level set to its top code but left disabled.
        set_reg(REG_OVR_LEVEL, 32'd7);
        set_reg(REG_OVR_ENABLE, 32'd0);

        // Directed part: every level code, a repeated level, and the first
        // steps of the microsleep ramp.
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, LVL_PRE_DROWSY);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_TICK, 3'd7);
        queue_item(CMD_EVENT, LVL_PRE_DROWSY);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, LVL_DROWSY);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, LVL_DISTRACTED);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, 3'd5);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, 3'd6);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, 3'd7);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_item(CMD_EVENT, LVL_AWAKE);
        queue_item(CMD_TICK, LVL_AWAKE);

        // A long microsleep stretch runs the ramp to its steady end.
        queue_item(CMD_EVENT, LVL_MICROSLEEP);
        repeat (405) queue_item(CMD_TICK, 3'($urandom_range(7)));
        queue_item(CMD_EVENT, LVL_MICROSLEEP);
        queue_item(CMD_TICK, LVL_AWAKE);
        queue_level_runs(70);
        wait_drained();

        // Override forces microsleep; incoming events must be dropped.
        set_reg(REG_OVR_LEVEL, 32'(LVL_MICROSLEEP));
        set_reg(REG_OVR_ENABLE, 32'd1);
        idle_pct  = 83;
        stall_pct = 0;
        queue_level_runs(70);
        wait_drained();

        // Override forced to the top undefined code, then to awake.
        set_reg(REG_OVR_LEVEL, 32'd7);
        idle_pct  = 0;
        stall_pct = 83;
        queue_level_runs(35);
        wait_drained();
        set_reg(REG_OVR_LEVEL, 32'(LVL_AWAKE));
        queue_level_runs(35);
        wait_drained();

        // Override off again: events take effect with both sides throttled.
        set_reg(REG_OVR_ENABLE, 32'd0);
        idle_pct  = 38;
        stall_pct = 38;
        queue_level_runs(70);
        wait_drained();

        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: alarm_blink_pattern_generator_top.f
hw/rtl/abpg_pkg.sv
hw/rtl/abpg_remdiv.sv
hw/rtl/abpg_datapath.sv
hw/rtl/abpg_ctrl.sv
hw/rtl/alarm_blink_pattern_generator_top.sv
verif/tb_top.sv
